FILE: sv/byte_ring_fifo_chunked_read_top_macros.svh
// assertion helpers used by the ring fifo back engine
`ifndef BYTE_RING_FIFO_CHUNKED_READ_TOP_MACROS_SVH
`define BYTE_RING_FIFO_CHUNKED_READ_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define BRFCR_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BRFCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/brfcr_pkg.sv
package brfcr_pkg;

    localparam int DEPTH_DEF = 16384;
    localparam int CHUNK_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int DATA_W   = 8;
    localparam int LEN_W    = 14;
    localparam int STAT_W   = 2;
    localparam int SIZE_W   = 6;
    localparam int REM_W    = 10;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PURGE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PURGED  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0]   data_in;
        logic                first_of_block;
        logic [LEN_W-1:0]    block_length;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] data_out;
        logic              is_last;
        logic [SIZE_W-1:0] chunk_size;
        logic [REM_W-1:0]  chunks_remaining;
    } t_out;

    // classified request handed from front to back
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0]   data;
        logic                opens;
        logic [LEN_W-1:0]    len;
    } t_cmd;

endpackage

FILE: sv/brfcr_front.sv
module brfcr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  brfcr_pkg::t_in   i_in_data,
    output logic             o_cmd_valid,
    input  logic             i_cmd_pop,
    output brfcr_pkg::t_cmd  o_cmd
);
    import brfcr_pkg::*;

    t_cmd       r_q [2];
    logic       r_head;
    logic       r_tail;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cmd       w_cmd;
    logic       w_push;

    // a byte without first_of_block counts as a one-byte block if none is open
    always_comb begin
        w_cmd.action = i_in_data.action;
        w_cmd.data   = i_in_data.data_in;
        w_cmd.opens  = i_in_data.first_of_block;
        w_cmd.len    = i_in_data.first_of_block ? i_in_data.block_length : LEN_W'(1);
    end

    assign o_in_ready  = (r_count != 2'd2);
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_head];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_cmd_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_cmd_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_tail <= ~r_tail;
            end
            if (i_cmd_pop) begin
                r_head <= ~r_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_tail] <= w_cmd;
        end
    end

endmodule

FILE: sv/brfcr_cdiv.sv
module brfcr_cdiv #(
    parameter int CHUNK = brfcr_pkg::CHUNK_DEF,
    parameter int XW    = 21
) (
    input  logic                         i_clk,
    input  logic [XW-1:0]                i_x,
    output logic [brfcr_pkg::REM_W-1:0]  o_quot
);
    import brfcr_pkg::*;

    // floor(x / CHUNK) as x * ceil(2^SH / CHUNK) >> SH, exact for any XW-bit x
    localparam int SH_L = $clog2(CHUNK);
    localparam int SH   = XW + SH_L;
    localparam int MW   = XW + 2;
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(CHUNK) - 64'd1) / 64'(CHUNK);
    localparam logic [MW-1:0] MULT = RECIP[MW-1:0];

    logic [XW+MW-1:0] r_prod;
    logic [XW+MW-1:0] w_shift;

    always_ff @(posedge i_clk) begin
        r_prod <= {{MW{1'b0}}, i_x} * {{XW{1'b0}}, MULT};
    end

    assign w_shift = r_prod >> SH;
    assign o_quot  = w_shift[REM_W-1:0];

endmodule

FILE: sv/brfcr_back.sv
`include "byte_ring_fifo_chunked_read_top_macros.svh"

module brfcr_back #(
    parameter int DEPTH = brfcr_pkg::DEPTH_DEF,
    parameter int CHUNK = brfcr_pkg::CHUNK_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_pop,
    input  brfcr_pkg::t_cmd  i_cmd,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output brfcr_pkg::t_out  o_out
);
    import brfcr_pkg::*;

    localparam int PW  = $clog2(DEPTH);
    localparam int XW  = PW + 7;
    localparam int CNW = $clog2(CHUNK + 1);
    localparam int CW  = (PW > LEN_W) ? PW + 1 : LEN_W + 1;

    localparam logic [PW-1:0] LAST_IDX   = PW'(DEPTH - 1);
    localparam logic [XW-1:0] CHUNK_X    = XW'(CHUNK);
    localparam logic [XW-1:0] CHUNK_M1_X = XW'(CHUNK - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_QOUT = 2'd3;

    logic [DATA_W-1:0] r_mem [DEPTH];

    logic [1:0]        r_state, n_state;
    logic [PW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_rp, n_rp;
    logic              r_purge, n_purge;
    logic [LEN_W-1:0]  r_bbl, n_bbl;
    logic              r_refused, n_refused;
    logic [CNW-1:0]    r_left, n_left;
    logic              r_rd_pend, n_rd_pend;
    logic              r_out_valid, n_out_valid;
    logic              r_is_query, n_is_query;
    logic              r_rd_last, n_rd_last;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [XW-1:0]     r_x, n_x;
    logic [DATA_W-1:0] r_rd_data;
    t_out              r_out, n_out;

    logic [PW:0]       w_diff;
    logic [PW-1:0]     w_used;
    logic [PW-1:0]     w_free;
    logic [XW-1:0]     w_used_x;
    logic [XW-1:0]     w_n_x;
    logic [PW-1:0]     w_wp_inc;
    logic [PW-1:0]     w_rp_inc;
    logic [REM_W-1:0]  w_quot;
    logic              w_can_load;
    logic              w_start;
    logic              w_zero_len;
    logic [LEN_W-1:0]  w_p_bbl;
    logic              w_p_ref;
    logic              w_p_store;
    logic              w_issue;
    logic              w_load_byte;
    logic              w_wr_en;
    logic              w_rd_en;
    logic              w_pop;

    // occupancy from the pointer pair
    always_comb begin
        w_diff = {1'b0, r_wp} - {1'b0, r_rp};
        if (r_wp < r_rp) begin
            w_diff = w_diff + (PW + 1)'(DEPTH);
        end
    end

    assign w_used     = w_diff[PW-1:0];
    assign w_free     = LAST_IDX - w_used;
    assign w_used_x   = {7'd0, w_used};
    assign w_n_x      = (w_used_x < CHUNK_X) ? w_used_x : CHUNK_X;
    assign w_wp_inc   = (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
    assign w_rp_inc   = (r_rp == LAST_IDX) ? '0 : r_rp + 1'b1;
    assign w_can_load = !r_out_valid || i_out_ready;

    // block admission for a put byte
    always_comb begin
        w_start    = i_cmd.opens || (r_bbl == '0);
        w_zero_len = 1'b0;
        w_p_bbl    = r_bbl - 1'b1;
        w_p_ref    = r_refused;
        if (w_start) begin
            if (i_cmd.len == '0) begin
                w_zero_len = 1'b1;
                w_p_bbl    = '0;
                w_p_ref    = 1'b0;
            end else begin
                w_p_bbl = i_cmd.len - 1'b1;
                w_p_ref = CW'(w_free) < CW'(i_cmd.len);
            end
        end
        w_p_store = !w_zero_len && !w_p_ref && (w_free != '0);
    end

    assign w_issue     = (r_state == S_RUN) && (r_left != '0) && (!r_rd_pend || w_can_load);
    assign w_load_byte = (r_state == S_RUN) && r_rd_pend && w_can_load;

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_purge     = r_purge;
        n_bbl       = r_bbl;
        n_refused   = r_refused;
        n_left      = r_left;
        n_rd_pend   = r_rd_pend;
        n_is_query  = r_is_query;
        n_rd_last   = r_rd_last;
        n_size      = r_size;
        n_x         = r_x;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_pop       = 1'b0;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.action)
                        ACT_PUT: begin
                            if (w_can_load) begin
                                w_pop       = 1'b1;
                                n_bbl       = w_p_bbl;
                                n_refused   = w_p_ref;
                                w_wr_en     = w_p_store;
                                if (w_p_store) begin
                                    n_wp = w_wp_inc;
                                end
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                n_out.status  = w_p_store ? STAT_OK : STAT_REFUSED;
                                n_out.is_last = 1'b1;
                            end
                        end
                        ACT_GET: begin
                            if (r_purge || (w_used == '0)) begin
                                if (w_can_load) begin
                                    w_pop         = 1'b1;
                                    n_purge       = 1'b0;
                                    n_out_valid   = 1'b1;
                                    n_out         = '0;
                                    n_out.status  = r_purge ? STAT_PURGED : STAT_EMPTY;
                                    n_out.is_last = 1'b1;
                                end
                            end else begin
                                w_pop      = 1'b1;
                                n_left     = w_n_x[CNW-1:0];
                                n_size     = w_n_x[SIZE_W-1:0];
                                n_x        = w_used_x - w_n_x + CHUNK_M1_X;
                                n_is_query = 1'b0;
                                n_state    = S_MUL;
                            end
                        end
                        ACT_PURGE: begin
                            w_pop   = 1'b1;
                            n_wp    = '0;
                            n_rp    = '0;
                            n_purge = 1'b1;
                        end
                        ACT_QUERY: begin
                            w_pop      = 1'b1;
                            n_x        = w_used_x + CHUNK_M1_X;
                            n_is_query = 1'b1;
                            n_state    = S_MUL;
                        end
                        default: begin
                            w_pop = 1'b0;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_state = r_is_query ? S_QOUT : S_RUN;
            end
            S_RUN: begin
                if (w_load_byte) begin
                    n_out_valid            = 1'b1;
                    n_out.status           = STAT_OK;
                    n_out.data_out         = r_rd_data;
                    n_out.is_last          = r_rd_last;
                    n_out.chunk_size       = r_size;
                    n_out.chunks_remaining = w_quot;
                end
                if (w_issue) begin
                    w_rd_en   = 1'b1;
                    n_rp      = w_rp_inc;
                    n_left    = r_left - 1'b1;
                    n_rd_last = (r_left == CNW'(1));
                    n_rd_pend = 1'b1;
                end else if (w_load_byte) begin
                    n_rd_pend = 1'b0;
                end
                if ((r_left == '0) && (!r_rd_pend || w_load_byte)) begin
                    n_state = S_IDLE;
                end
            end
            S_QOUT: begin
                if (w_can_load) begin
                    n_out_valid            = 1'b1;
                    n_out                  = '0;
                    n_out.status           = STAT_OK;
                    n_out.is_last          = 1'b1;
                    n_out.chunks_remaining = w_quot;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_purge     <= 1'b0;
            r_bbl       <= '0;
            r_refused   <= 1'b0;
            r_left      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_purge     <= n_purge;
            r_bbl       <= n_bbl;
            r_refused   <= n_refused;
            r_left      <= n_left;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_query <= n_is_query;
        r_rd_last  <= n_rd_last;
        r_size     <= n_size;
        r_x        <= n_x;
        r_out      <= n_out;
    end

    // byte store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wp] <= i_cmd.data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    brfcr_cdiv #(
        .CHUNK (CHUNK),
        .XW    (XW)
    ) u_cdiv (
        .i_clk  (i_clk),
        .i_x    (r_x),
        .o_quot (w_quot)
    );

    assign o_cmd_pop   = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `BRFCR_ASSERT(a_no_write_full, i_clk, i_rst_n, w_wr_en, w_used != LAST_IDX, "write into full ring")
    `BRFCR_ASSERT(a_no_read_empty, i_clk, i_rst_n, w_rd_en, w_used != '0, "read from empty ring")
    `BRFCR_ASSERT(a_idle_drained, i_clk, i_rst_n, r_state == S_IDLE, !r_rd_pend && (r_left == '0), "idle with read in flight")
    `BRFCR_ASSERT_NEXT(a_purge_clears, i_clk, i_rst_n, w_pop && (i_cmd.action == ACT_PURGE), r_purge && (r_wp == '0) && (r_rp == '0), "purge did not empty ring")

endmodule

FILE: sv/byte_ring_fifo_chunked_read_top.sv
// Byte ring fifo with all-or-nothing block admission and chunked reads. DEPTH byte slots, one
// always kept free, so at most DEPTH-1 bytes are held. A put request stores one byte; the first
// byte of a block carries the block length and the whole block is refused (every byte answered
// with status 1) if the free space is short. A get reports and clears a pending purge notice,
// answers empty once on an empty ring, or streams up to CHUNK bytes, one result per byte, the
// last one flagged, each carrying the chunk size and the chunks still left, rounded up. A purge
// resets both pointers, raises the purge notice and gives no result. A query returns the ready
// chunk count. A small front queue takes requests while the back engine works. Puts and purges
// retire one per cycle, puts only while the output is free. A get with data is dispatched,
// passes the registered constant-reciprocal multiply behind the chunk count, then streams one
// byte per cycle unless stalled, through the single read port of the byte store. A query passes
// both, then answers; a purged or empty get answers at dispatch. Results sit in an output
// register, so a stalled consumer only holds the back engine; the front queue still fills.
module byte_ring_fifo_chunked_read_top #(
    parameter int DEPTH = brfcr_pkg::DEPTH_DEF,
    parameter int CHUNK = brfcr_pkg::CHUNK_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  brfcr_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output brfcr_pkg::t_out o_out_data
);
    import brfcr_pkg::*;

    // front to back request queue handshake
    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_cmd;

    // front: accepts requests, classifies put bytes, buffers two requests
    brfcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd)
    );

    // back: pointers, byte store, block admission, chunked read-out, output register
    brfcr_back #(
        .DEPTH (DEPTH),
        .CHUNK (CHUNK)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule
